// File: design/dbs_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the DLE byte stuffer / destuffer.
// No dependencies; used by every module of the block.
package dbs_pkg;

    localparam logic [7:0] DLE_CODE = 8'd16;
    localparam logic [7:0] STX_CODE = 8'd2;
    localparam logic [7:0] ETX_CODE = 8'd3;

    localparam logic MODE_STUFF   = 1'b0;
    localparam logic MODE_DESTUFF = 1'b1;

    // Positions in a job's step mask, in output order
    localparam int STEP_W       = 6;
    localparam int STEP_HDR_DLE = 0;
    localparam int STEP_HDR_STX = 1;
    localparam int STEP_DBL_DLE = 2;
    localparam int STEP_DATA    = 3;
    localparam int STEP_TRL_DLE = 4;
    localparam int STEP_TRL_ETX = 5;

    // Flags carried by the data step of a job
    typedef struct packed {
        logic bad_escape;
        logic frame_end;
        logic frame_start;
        logic byte_valid;
    } t_flags;

    // One classified input item: which results it expands to
    typedef struct packed {
        logic [STEP_W-1:0] steps;
        logic [7:0]        data_byte;
        t_flags            flags;
    } t_job;

endpackage

// File: design/dbs_front.sv
`timescale 1ns / 1ps
// Front end: accepts input transactions, tracks framing state, classifies
// each item into a job for the back end. Depends on dbs_pkg.
module dbs_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_wdata,
    input  logic          i_accept,
    input  logic [7:0]    i_data_byte,
    input  logic          i_has_byte,
    input  logic          i_end_frame,
    output logic          o_push,
    output dbs_pkg::t_job o_job
);

    logic r_mode;
    logic r_in_frame;
    logic r_esc;
    logic n_in_frame;
    logic n_esc;
    dbs_pkg::t_job job;

    always_comb begin
        n_in_frame = r_in_frame;
        n_esc      = r_esc;
        job        = '0;
        if (r_mode == dbs_pkg::MODE_STUFF) begin
            if (i_has_byte || i_end_frame) begin
                job.steps[dbs_pkg::STEP_HDR_DLE] = !r_in_frame;
                job.steps[dbs_pkg::STEP_HDR_STX] = !r_in_frame;
                job.steps[dbs_pkg::STEP_DBL_DLE] = i_has_byte &&
                                                   (i_data_byte == dbs_pkg::DLE_CODE);
                job.steps[dbs_pkg::STEP_DATA]    = i_has_byte;
                job.steps[dbs_pkg::STEP_TRL_DLE] = i_end_frame;
                job.steps[dbs_pkg::STEP_TRL_ETX] = i_end_frame;
                job.data_byte        = i_data_byte;
                job.flags.byte_valid = 1'b1;
                n_in_frame           = !i_end_frame;
            end
        end else if (i_has_byte) begin
            if (!r_esc) begin
                if (i_data_byte == dbs_pkg::DLE_CODE) begin
                    n_esc = 1'b1;
                end else if (r_in_frame) begin
                    job.steps[dbs_pkg::STEP_DATA] = 1'b1;
                    job.data_byte                 = i_data_byte;
                    job.flags.byte_valid          = 1'b1;
                end
            end else begin
                n_esc = 1'b0;
                if (i_data_byte == dbs_pkg::STX_CODE) begin
                    n_in_frame                    = 1'b1;
                    job.steps[dbs_pkg::STEP_DATA] = 1'b1;
                    job.flags.frame_start         = 1'b1;
                end else if (r_in_frame) begin
                    job.steps[dbs_pkg::STEP_DATA] = 1'b1;
                    if (i_data_byte == dbs_pkg::ETX_CODE) begin
                        n_in_frame          = 1'b0;
                        job.flags.frame_end = 1'b1;
                    end else if (i_data_byte == dbs_pkg::DLE_CODE) begin
                        job.data_byte        = dbs_pkg::DLE_CODE;
                        job.flags.byte_valid = 1'b1;
                    end else begin
                        job.flags.bad_escape = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= dbs_pkg::MODE_STUFF;
            r_in_frame <= 1'b0;
            r_esc      <= 1'b0;
        end else if (i_cfg_we) begin
            r_mode     <= i_cfg_wdata;
            r_in_frame <= 1'b0;
            r_esc      <= 1'b0;
        end else if (i_accept) begin
            r_in_frame <= n_in_frame;
            r_esc      <= n_esc;
        end
    end

    assign o_push = i_accept && (job.steps != '0);
    assign o_job  = job;

endmodule

// File: design/dbs_fifo.sv
`timescale 1ns / 1ps
// Small job queue between front and back end, fall-through head read.
// Depends on dbs_pkg.
module dbs_fifo #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dbs_pkg::t_job i_job,
    output logic          o_not_full,
    input  logic          i_pop,
    output logic          o_valid,
    output dbs_pkg::t_job o_job
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    dbs_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_not_full = (r_cnt != CW'(DEPTH));
    assign o_valid    = (r_cnt != '0);
    assign o_job      = r_mem[r_rd];

endmodule

// File: design/dbs_back.sv
`timescale 1ns / 1ps
// Back end: expands queued jobs into result transactions, one per cycle
// unless stalled, through a registered output stage. Depends on dbs_pkg.
module dbs_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    input  dbs_pkg::t_job i_job,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [7:0]    o_byte,
    output dbs_pkg::t_flags o_flags,
    output logic          o_last
);

    logic                       r_busy;
    logic [dbs_pkg::STEP_W-1:0] r_steps;
    logic [7:0]                 r_byte;
    dbs_pkg::t_flags            r_flags;

    logic                       r_out_valid;
    logic [7:0]                 r_out_byte;
    dbs_pkg::t_flags            r_out_flags;
    logic                       r_out_last;

    logic                       out_load;
    logic                       emit;
    logic [dbs_pkg::STEP_W-1:0] rest;
    logic                       work_free;
    logic [7:0]                 step_byte;
    dbs_pkg::t_flags            step_flags;

    assign out_load  = !r_out_valid || i_ready;
    assign emit      = r_busy && out_load;
    assign rest      = r_steps & (r_steps - 1'b1);
    assign work_free = !r_busy || (emit && (rest == '0));
    assign o_pop     = i_job_valid && work_free;

    // Lowest pending step picks the byte
    always_comb begin
        step_flags = '0;
        step_flags.byte_valid = 1'b1;
        if (r_steps[dbs_pkg::STEP_HDR_DLE]) begin
            step_byte = dbs_pkg::DLE_CODE;
        end else if (r_steps[dbs_pkg::STEP_HDR_STX]) begin
            step_byte = dbs_pkg::STX_CODE;
        end else if (r_steps[dbs_pkg::STEP_DBL_DLE]) begin
            step_byte = dbs_pkg::DLE_CODE;
        end else if (r_steps[dbs_pkg::STEP_DATA]) begin
            step_byte  = r_byte;
            step_flags = r_flags;
        end else if (r_steps[dbs_pkg::STEP_TRL_DLE]) begin
            step_byte = dbs_pkg::DLE_CODE;
        end else begin
            step_byte = dbs_pkg::ETX_CODE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
        end else if (emit) begin
            r_busy <= (rest != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_steps <= i_job.steps;
            r_byte  <= i_job.data_byte;
            r_flags <= i_job.flags;
        end else if (emit) begin
            r_steps <= rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte  <= step_byte;
            r_out_flags <= step_flags;
            r_out_last  <= (rest == '0);
        end
    end

    assign o_valid = r_out_valid;
    assign o_byte  = r_out_byte;
    assign o_flags = r_out_flags;
    assign o_last  = r_out_last;

endmodule

// File: design/dle_byte_stuff_destuff.sv
`timescale 1ns / 1ps
// DLE STX / DLE ETX byte stuffer and destuffer (DLE=16, STX=2, ETX=3).
// Top level; instantiates dbs_front, dbs_fifo and dbs_back, uses dbs_pkg.
//
// The mode register picks the direction: 0 stuffs raw bytes into frames,
// 1 hunts a stuffed stream for DLE STX and recovers the frame payload,
// flagging frame start, frame end and bad escapes. Writing the mode also
// clears the framing state; write it only while the block is idle. The
// front end accepts one input transaction per cycle as long as the job
// queue (FIFO_DEPTH entries) has room; the back end sends one result
// transaction per cycle while the output is ready, so the output side
// sets sustained rate. An item yields 0 to 6 results (a mid-frame byte
// gives 1, or 2 for a doubled DLE); items with no result skip the queue.
// A result passes the job queue, the back end's work register and the
// output register. tlast on the output marks the last result of an item.
module dle_byte_stuff_destuff #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Configuration: mode register
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    // Input stream
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0] s_axis_tuser,   // [0] has_byte
    input  logic       s_axis_tlast,   // end_frame
    // Output stream
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [3:0] m_axis_tuser,   // [0] byte_valid, [1] frame_start,
                                       // [2] frame_end, [3] bad_escape
    output logic       m_axis_tlast    // last_of_run
);

    logic            in_accept;
    logic            push;
    dbs_pkg::t_job   push_job;
    logic            not_full;
    logic            pop;
    logic            head_valid;
    dbs_pkg::t_job   head_job;
    dbs_pkg::t_flags out_flags;

    // Input transaction completes whenever the queue can take a job
    assign s_axis_tready = not_full;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    dbs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (in_accept),
        .i_data_byte (s_axis_tdata),
        .i_has_byte  (s_axis_tuser[0]),
        .i_end_frame (s_axis_tlast),
        .o_push      (push),
        .o_job       (push_job)
    );

    dbs_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_job      (push_job),
        .o_not_full (not_full),
        .i_pop      (pop),
        .o_valid    (head_valid),
        .o_job      (head_job)
    );

    dbs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (head_valid),
        .i_job       (head_job),
        .o_pop       (pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_byte      (m_axis_tdata),
        .o_flags     (out_flags),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tuser = {out_flags.bad_escape, out_flags.frame_end,
                           out_flags.frame_start, out_flags.byte_valid};

endmodule

// File: tb/dle_byte_stuff_destuff_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for dle_byte_stuff_destuff: directed and random traffic
// in both directions. Depends on dbs_pkg and the dle_byte_stuff_destuff RTL.
import dbs_pkg::*;

// One predicted output transaction
typedef struct packed {
    logic [7:0] out_byte;
    t_flags     flags;
    logic       last;
} dle_result_t;

// Tracks framing state and holds the results still owed by the block
class dle_frame_sb;
    logic        mode;
    bit          in_frame;
    bit          dle_held;
    dle_result_t due_q[$];
    int          errors;

    function new();
        mode     = MODE_STUFF;
        in_frame = 1'b0;
        dle_held = 1'b0;
        errors   = 0;
    endfunction

    // A mode write also drops any open frame and a held DLE
    function void set_mode(logic m);
        mode     = m;
        in_frame = 1'b0;
        dle_held = 1'b0;
    endfunction

    function void push(logic [7:0] b, logic v, logic s, logic e, logic x);
        dle_result_t r;
        r.out_byte          = b;
        r.flags.byte_valid  = v;
        r.flags.frame_start = s;
        r.flags.frame_end   = e;
        r.flags.bad_escape  = x;
        r.last              = 1'b0;
        due_q.push_back(r);
    endfunction

    // Called once per accepted input transaction
    function void note_item(logic [7:0] d, logic has, logic eof);
        int mark;
        mark = due_q.size();
        if (mode == MODE_STUFF) begin
            if (has || eof) begin
                if (!in_frame) begin
                    push(DLE_CODE, 1'b1, 1'b0, 1'b0, 1'b0);
                    push(STX_CODE, 1'b1, 1'b0, 1'b0, 1'b0);
                    in_frame = 1'b1;
                end
                if (has) begin
                    if (d == DLE_CODE)
                        push(DLE_CODE, 1'b1, 1'b0, 1'b0, 1'b0);
                    push(d, 1'b1, 1'b0, 1'b0, 1'b0);
                end
                if (eof) begin
                    push(DLE_CODE, 1'b1, 1'b0, 1'b0, 1'b0);
                    push(ETX_CODE, 1'b1, 1'b0, 1'b0, 1'b0);
                    in_frame = 1'b0;
                end
            end
        end else if (has) begin
            if (!dle_held) begin
                if (d == DLE_CODE)
                    dle_held = 1'b1;
                else if (in_frame)
                    push(d, 1'b1, 1'b0, 1'b0, 1'b0);
            end else begin
                dle_held = 1'b0;
                if (d == STX_CODE) begin
                    in_frame = 1'b1;
                    push(8'd0, 1'b0, 1'b1, 1'b0, 1'b0);
                end else if (in_frame) begin
                    if (d == ETX_CODE) begin
                        in_frame = 1'b0;
                        push(8'd0, 1'b0, 1'b0, 1'b1, 1'b0);
                    end else if (d == DLE_CODE) begin
                        push(DLE_CODE, 1'b1, 1'b0, 1'b0, 1'b0);
                    end else begin
                        push(8'd0, 1'b0, 1'b0, 1'b0, 1'b1);
                    end
                end
            end
        end
        if (due_q.size() > mark)
            due_q[due_q.size() - 1].last = 1'b1;
    endfunction

    function void cmp(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endfunction

    // Called once per accepted output transaction
    function void check_result(logic [7:0] d, logic [3:0] u, logic l);
        dle_result_t w;
        t_flags      got;
        if (due_q.size() == 0) begin
            $error("result with nothing pending: tdata %0d tuser %b tlast %b", d, u, l);
            errors++;
            return;
        end
        w   = due_q.pop_front();
        got = u;
        cmp("out_byte", w.out_byte, d);
        cmp("byte_valid", 8'(w.flags.byte_valid), 8'(got.byte_valid));
        cmp("frame_start", 8'(w.flags.frame_start), 8'(got.frame_start));
        cmp("frame_end", 8'(w.flags.frame_end), 8'(got.frame_end));
        cmp("bad_escape", 8'(w.flags.bad_escape), 8'(got.bad_escape));
        cmp("last_of_run", 8'(w.last), 8'(l));
    endfunction
endclass

module dle_byte_stuff_destuff_tb;

    localparam int SETTLE_CYCLES  = 10;    // idle margin for the pipeline and job queue to empty
    localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transaction on either side
    localparam int BLOCK_ITEMS    = 14;    // random items per mode per idle phase

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_cfg_we      = 1'b0;
    logic       i_cfg_wdata   = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'd0;
    logic [0:0] s_axis_tuser  = 1'b0;
    logic       s_axis_tlast  = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic [3:0] m_axis_tuser;
    logic       m_axis_tlast;

    dle_frame_sb sb;
    int          send_idle_pct  = 0;   // chance per cycle the sender holds off
    int          recv_stall_pct = 0;   // chance per cycle the receiver stalls
    int          items_sent     = 0;   // transactions the block acts on
    int          quiet_cycles   = 0;

    dle_byte_stuff_destuff dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 i_clk = ~i_clk;

    // Receiver: check each accepted result, then pick next cycle's tready
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: ends the run if neither side moves for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("dle_byte_stuff_destuff regression: fail");
            $finish;
        end
    end

    // Drive one input transaction; tvalid stays high afterwards so
    // back-to-back items need no extra edge. A random gap comes first.
    task automatic send_item(input logic [7:0] d, input logic has, input logic eof);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tuser  <= has;
        s_axis_tlast  <= eof;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        if (sb.mode == MODE_STUFF ? (has || eof) : has)
            items_sent++;
        sb.note_item(d, has, eof);
    endtask

    // Stop sending, let every pending result out, then let the pipe empty
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.due_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Mode writes only happen with the block fully idle
    task automatic write_mode(input logic m);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_mode(m);
    endtask

    // Byte picker biased toward the control codes
    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(99);
        if (r < 25)
            return DLE_CODE;
        if (r < 32)
            return STX_CODE;
        if (r < 38)
            return ETX_CODE;
        return 8'($urandom_range(255));
    endfunction

    // Raw bytes for the stuffer, with the odd empty item and frame close
    task automatic run_stuff(input int n);
        int stop;
        bit paused;
        stop   = items_sent + n;
        paused = 1'b0;
        while (items_sent < stop) begin
            if (!paused && items_sent >= stop - n / 2) begin
                drain();
                paused = 1'b1;
            end
            send_item(pick_byte(), $urandom_range(99) < 88, $urandom_range(99) < 18);
        end
    endtask

    // Stuffed stream for the destuffer: mostly well-formed frames, some
    // noise between them, bad escapes and frames left unterminated
    task automatic run_destuff(input int n);
        int         stop;
        int         len;
        bit         paused;
        logic [7:0] d;
        stop   = items_sent + n;
        paused = 1'b0;
        while (items_sent < stop) begin
            if (!paused && items_sent >= stop - n / 2) begin
                drain();
                paused = 1'b1;
            end
            if ($urandom_range(9) == 0) begin
                send_item(pick_byte(), 1'b1, 1'($urandom_range(1)));
                if ($urandom_range(3) == 0)
                    send_item(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)));
            end else begin
                send_item(DLE_CODE, 1'b1, 1'($urandom_range(1)));
                send_item(STX_CODE, 1'b1, 1'($urandom_range(1)));
                len = $urandom_range(6);
                repeat (len) begin
                    if ($urandom_range(99) < 8) begin
                        // DLE followed by a byte that is no valid escape
                        d = 8'($urandom_range(4, 255));
                        if (d == DLE_CODE)
                            d = 8'hFF;
                        send_item(DLE_CODE, 1'b1, 1'($urandom_range(1)));
                        send_item(d, 1'b1, 1'($urandom_range(1)));
                    end else begin
                        d = pick_byte();
                        if (d == DLE_CODE)
                            send_item(DLE_CODE, 1'b1, 1'($urandom_range(1)));
                        send_item(d, 1'b1, 1'($urandom_range(1)));
                    end
                end
                if ($urandom_range(9) != 0) begin
                    send_item(DLE_CODE, 1'b1, 1'($urandom_range(1)));
                    send_item(ETX_CODE, 1'b1, 1'($urandom_range(1)));
                end
            end
        end
    endtask

    initial begin
        int send_pcts[4];
        int recv_pcts[4];
        send_pcts = '{0, 63, 0, 13};
        recv_pcts = '{0, 0, 63, 13};
        sb = new();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed stuffing: empty item, empty frame, six-result item,
        // byte extremes, empty item mid-frame, close without a byte
        write_mode(MODE_STUFF);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(DLE_CODE, 1'b1, 1'b1);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(STX_CODE, 1'b1, 1'b0);
        send_item(8'h5A, 1'b0, 1'b0);
        send_item(ETX_CODE, 1'b0, 1'b1);

        // Directed destuffing: junk and escapes while hunting, then a frame
        // with data extremes, a DLE held across an empty item, a stuffed
        // DLE, a bad escape, a restart and the closing marker
        write_mode(MODE_DESTUFF);
        send_item(8'h55, 1'b1, 1'b0);
        send_item(DLE_CODE, 1'b1, 1'b0);
        send_item(DLE_CODE, 1'b1, 1'b0);
        send_item(DLE_CODE, 1'b1, 1'b1);
        send_item(ETX_CODE, 1'b1, 1'b0);
        send_item(DLE_CODE, 1'b1, 1'b0);
        send_item(8'h41, 1'b1, 1'b0);
        send_item(DLE_CODE, 1'b1, 1'b0);
        send_item(STX_CODE, 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b1);
        send_item(DLE_CODE, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(DLE_CODE, 1'b1, 1'b0);
        send_item(DLE_CODE, 1'b1, 1'b0);
        send_item(8'h7E, 1'b1, 1'b0);
        send_item(DLE_CODE, 1'b1, 1'b0);
        send_item(STX_CODE, 1'b1, 1'b0);
        send_item(DLE_CODE, 1'b1, 1'b0);
        send_item(ETX_CODE, 1'b1, 1'b0);

        // Random part: each idle phase covers both directions; every mode
        // switch clears whatever frame was left open
        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = send_pcts[p];
            recv_stall_pct = recv_pcts[p];
            write_mode(MODE_STUFF);
            run_stuff(BLOCK_ITEMS);
            write_mode(MODE_DESTUFF);
            run_destuff(BLOCK_ITEMS);
        end

        drain();
        if (sb.errors == 0 && sb.due_q.size() == 0)
            $display("dle_byte_stuff_destuff regression: pass");
        else
            $display("dle_byte_stuff_destuff regression: fail");
        $finish;
    end

endmodule

// File: files.f
design/dbs_pkg.sv
design/dbs_front.sv
design/dbs_fifo.sv
design/dbs_back.sv
design/dle_byte_stuff_destuff.sv
tb/dle_byte_stuff_destuff_tb.sv
